FILE: rtl/core/binary_min_heap_queue_macros.svh
// Assertion macros for the binary min-heap queue.
// Used by the top level; no other dependencies.
`ifndef BINARY_MIN_HEAP_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_MACROS_SVH

`ifndef SYNTH

// Checks that cond implies prop in the same cycle.
`define BMHQ_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("bmhq same-cycle check failed");

// Checks that cond implies prop in the next cycle.
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("bmhq next-cycle check failed");

`else

`define BMHQ_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

FILE: rtl/core/bmhq_pkg.sv
// Shared types and constants for the binary min-heap queue.
// No dependencies; the controller, datapath and top level import this package.
package bmhq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = CNT_W + 1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_PUSHED = 2'd0;
    localparam logic [1:0] ST_POPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // Input transaction.
    typedef struct packed {
        logic               op;
        logic [15:0]        item_data;
        logic signed [31:0] item_key;
    } t_in;

    // Result transaction.
    typedef struct packed {
        logic [15:0]      result_data;
        logic [1:0]       status;
        logic [CNT_W-1:0] entry_total;
    } t_out;

    // One heap entry as stored in memory.
    typedef struct packed {
        logic signed [31:0] key;
        logic [15:0]        data;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_UP_ISSUE,
        S_UP_RESOLVE,
        S_POP_LOAD,
        S_DOWN_ISSUE,
        S_DOWN_RESOLVE,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic dispatch;
        logic up_issue;
        logic up_resolve;
        logic pop_load;
        logic down_issue;
        logic down_resolve;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_pop;
        logic empty;
        logic full;
        logic at_root;
        logic up_swap;
        logic is_leaf;
        logic down_swap;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/core/bmhq_ctrl.sv
// Controller state machine for the binary min-heap queue.
// Depends on bmhq_pkg for the state, command and status types.
module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_stat  i_stat,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_stat.op_pop) begin
                    n_state = i_stat.empty ? S_FINISH : S_POP_LOAD;
                end else begin
                    n_state = i_stat.full ? S_FINISH : S_UP_ISSUE;
                end
            end
            S_UP_ISSUE: begin
                n_state = i_stat.at_root ? S_FINISH : S_UP_RESOLVE;
            end
            S_UP_RESOLVE: begin
                n_state = i_stat.up_swap ? S_UP_ISSUE : S_FINISH;
            end
            S_POP_LOAD: begin
                n_state = S_DOWN_ISSUE;
            end
            S_DOWN_ISSUE: begin
                n_state = i_stat.is_leaf ? S_FINISH : S_DOWN_RESOLVE;
            end
            S_DOWN_RESOLVE: begin
                n_state = i_stat.down_swap ? S_DOWN_ISSUE : S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output decode: at most one command per state.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_DISPATCH: begin
                o_cmd.dispatch = 1'b1;
            end
            S_UP_ISSUE: begin
                o_cmd.up_issue = 1'b1;
            end
            S_UP_RESOLVE: begin
                o_cmd.up_resolve = 1'b1;
            end
            S_POP_LOAD: begin
                o_cmd.pop_load = 1'b1;
            end
            S_DOWN_ISSUE: begin
                o_cmd.down_issue = 1'b1;
            end
            S_DOWN_RESOLVE: begin
                o_cmd.down_resolve = 1'b1;
            end
            S_FINISH: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/bmhq_datapath.sv
// Datapath for the binary min-heap queue: heap memory, moving entry,
// hole pointer, fill count and result register.
// Depends on bmhq_pkg for types and sizes.
module bmhq_datapath
    import bmhq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_in    i_in,
    input  t_cmd   i_cmd,
    output t_stat  o_stat,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_out   o_out
);

    // Heap storage, position p lives in slot p-1.
    t_entry r_mem [CAPACITY];
    t_entry r_rd_a;
    t_entry r_rd_b;

    logic              r_op;
    logic signed [31:0] r_mkey;
    logic [15:0]       r_mdata;
    logic [CNT_W-1:0]  r_hole;
    logic [CNT_W-1:0]  r_count;
    logic [15:0]       r_res_data;
    logic [1:0]        r_status;
    logic              r_out_valid;
    t_out              r_out;

    logic [CNT_W-1:0]  w_hole_m1;
    logic [CNT_W-1:0]  w_parent;
    logic [CNT_W-1:0]  w_parent_m1;
    logic [CNT_W-1:0]  w_count_m1;
    logic [POS_W-1:0]  w_left;
    logic [POS_W-1:0]  w_right;
    logic [POS_W-1:0]  w_left_m1;
    logic [POS_W-1:0]  w_count_x;
    logic              w_left_ok;
    logic              w_right_ok;
    logic              w_pick_left;
    logic              w_pick_right;
    logic signed [31:0] w_best_key;
    logic [POS_W-1:0]  w_best_pos;
    t_entry            w_child;
    t_entry            w_moving;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    t_entry            w_wdata;
    logic [ADDR_W-1:0] w_raddr_a;
    logic [ADDR_W-1:0] w_raddr_b;

    // Position arithmetic around the hole.
    assign w_hole_m1   = r_hole - 1'b1;
    assign w_parent    = r_hole >> 1;
    assign w_parent_m1 = w_parent - 1'b1;
    assign w_count_m1  = r_count - 1'b1;
    assign w_left      = {r_hole, 1'b0};
    assign w_right     = w_left + 1'b1;
    assign w_left_m1   = w_left - 1'b1;
    assign w_count_x   = {1'b0, r_count};
    assign w_left_ok   = (w_left <= w_count_x);
    assign w_right_ok  = (w_right <= w_count_x);
    assign w_moving    = '{key: r_mkey, data: r_mdata};

    // Child selection: left wins ties, right only when strictly lighter.
    assign w_pick_left  = w_left_ok && ($signed(r_rd_a.key) < r_mkey);
    assign w_best_key   = w_pick_left ? r_rd_a.key : r_mkey;
    assign w_pick_right = w_right_ok && ($signed(r_rd_b.key) < w_best_key);
    assign w_child      = w_pick_right ? r_rd_b : r_rd_a;
    assign w_best_pos   = w_pick_right ? w_right : w_left;

    // Status toward the controller.
    assign o_stat.op_pop    = (r_op == OP_POP);
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CNT_W'(CAPACITY));
    assign o_stat.at_root   = (r_hole == CNT_W'(1));
    assign o_stat.up_swap   = (r_mkey < $signed(r_rd_a.key));
    assign o_stat.is_leaf   = !w_left_ok;
    assign o_stat.down_swap = w_pick_left || w_pick_right;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // Memory write selection.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_hole_m1[ADDR_W-1:0];
        w_wdata = w_moving;
        if (i_cmd.up_issue && o_stat.at_root) begin
            w_we = 1'b1;
        end else if (i_cmd.up_resolve) begin
            w_we    = 1'b1;
            w_wdata = o_stat.up_swap ? r_rd_a : w_moving;
        end else if (i_cmd.down_issue && !w_left_ok) begin
            w_we = 1'b1;
        end else if (i_cmd.down_resolve) begin
            w_we    = 1'b1;
            w_wdata = o_stat.down_swap ? w_child : w_moving;
        end
    end

    // Memory read address selection.
    always_comb begin
        w_raddr_a = '0;
        w_raddr_b = '0;
        if (i_cmd.dispatch) begin
            w_raddr_b = w_count_m1[ADDR_W-1:0];
        end else if (i_cmd.up_issue) begin
            w_raddr_a = w_parent_m1[ADDR_W-1:0];
        end else if (i_cmd.down_issue) begin
            w_raddr_a = w_left_m1[ADDR_W-1:0];
            w_raddr_b = w_left[ADDR_W-1:0];
        end
    end

    // Heap memory with one write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= r_mem[w_raddr_a];
        r_rd_b <= r_mem[w_raddr_b];
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.dispatch) begin
            if (r_op == OP_PUSH && !o_stat.full) begin
                r_count <= r_count + 1'b1;
            end else if (r_op == OP_POP && !o_stat.empty) begin
                r_count <= w_count_m1;
            end
        end
    end

    // Moving entry, hole pointer and result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= i_in.op;
            r_mkey  <= i_in.item_key;
            r_mdata <= i_in.item_data;
        end
        if (i_cmd.dispatch) begin
            r_res_data <= '0;
            if (r_op == OP_PUSH) begin
                r_hole   <= r_count + 1'b1;
                r_status <= o_stat.full ? ST_FULL : ST_PUSHED;
            end else begin
                r_hole   <= CNT_W'(1);
                r_status <= o_stat.empty ? ST_EMPTY : ST_POPPED;
            end
        end
        if (i_cmd.pop_load) begin
            r_res_data <= r_rd_a.data;
            r_mkey     <= r_rd_b.key;
            r_mdata    <= r_rd_b.data;
        end
        if (i_cmd.up_resolve && o_stat.up_swap) begin
            r_hole <= w_parent;
        end
        if (i_cmd.down_resolve && o_stat.down_swap) begin
            r_hole <= w_best_pos[CNT_W-1:0];
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.result_data <= r_res_data;
            r_out.status      <= r_status;
            r_out.entry_total <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: rtl/core/binary_min_heap_queue.sv
// Binary min-heap priority queue of up to 64 entries, each a signed 32-bit key with a
// 16-bit data word; a push sifts the entry up, a pop returns the lightest entry's data
// (left child wins ties) and every transaction yields exactly one result with status
// and entry count. Items are handled one at a time: the next item is accepted only
// after the current one has finished. Each heap level climbed or descended costs one
// registered read, compare and write-back of the single heap memory; a pop on an empty
// queue or a push to a full one goes straight to its result. Before the next item is
// accepted the block also waits for the previous result to be taken. A finished
// result waits in an output register while the next transaction is taken in.
// Depends on bmhq_pkg, bmhq_ctrl, bmhq_datapath and the assertion macro header.
`include "binary_min_heap_queue_macros.svh"

module binary_min_heap_queue
    import bmhq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer for push and pop.
    bmhq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Heap storage and result register.
    bmhq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Only one transaction is in work at a time.
    `BMHQ_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // The fill count never passes the capacity.
    `BMHQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, o_out_valid, o_out.entry_total <= CNT_W'(CAPACITY))

    // Only a successful pop carries data.
    `BMHQ_ASSERT_SAME(a_data_zero, i_clk, i_rst_n, o_out_valid && (o_out.status != ST_POPPED), o_out.result_data == 16'd0)

    // Empty and full reports agree with the count.
    `BMHQ_ASSERT_SAME(a_empty_count, i_clk, i_rst_n, o_out_valid && (o_out.status == ST_EMPTY), o_out.entry_total == '0)
    `BMHQ_ASSERT_SAME(a_full_count, i_clk, i_rst_n, o_out_valid && (o_out.status == ST_FULL), o_out.entry_total == CNT_W'(CAPACITY))

endmodule
